// ----- rtl/core/shrb_pkg.sv -----
// Shared types, sizes and helpers for the sequenced history ring buffer.
// Used by shrb_front, shrb_back and sequenced_history_ring_buffer; no dependencies.
`timescale 1ns / 1ps

package shrb_pkg;

    // Buffer geometry
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 64;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = CNT_W + 1;

    // Fixed field widths of the ports
    localparam int ID_W     = 64;
    localparam int FRAME_W  = 64;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    // Command queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;
    localparam int QFILL_W = 2;

    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [ID_W-1:0]       id_t;
    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [FRAME_W-1:0]    frame_t;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 2'd0,
        OP_GET     = 2'd1,
        OP_DISCARD = 2'd2,
        OP_PURGE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_EVICTED   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CALC,
        BK_EXEC,
        BK_READ
    } back_state_t;

    // One classified command as it travels from front to back
    typedef struct packed {
        op_t   op;
        id_t   qid;
        data_t data;
    } cmd_t;

    // Add an offset (at most DEPTH) to a slot index, modulo DEPTH
    function automatic idx_t wrap_add(idx_t a, cnt_t b);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s >= SUM_W'(DEPTH))
        begin
            s = s - SUM_W'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

// ----- rtl/core/shrb_front.sv -----
// Front end: accepts input beats, decodes the operation and queues commands.
// Depends on shrb_pkg (cmd_t, queue sizes).
`timescale 1ns / 1ps

module shrb_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [shrb_pkg::OP_W-1:0]        op,
    input  logic [shrb_pkg::ID_W-1:0]        query_id,
    input  logic [shrb_pkg::FRAME_W-1:0]     frame_data,
    output logic                             cmd_valid,
    input  logic                             cmd_ready,
    output shrb_pkg::cmd_t                   cmd
);

    shrb_pkg::cmd_t                    q_mem_reg [shrb_pkg::QDEPTH];
    logic [shrb_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [shrb_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [shrb_pkg::QFILL_W-1:0]      fill_reg, fill_next;
    shrb_pkg::cmd_t                    entry_in;
    logic                              push;
    logic                              pop;

    // Classify the incoming beat and keep only the stored payload bits
    always_comb
    begin
        entry_in.op   = shrb_pkg::op_t'(op);
        entry_in.qid  = query_id;
        entry_in.data = frame_data[shrb_pkg::DATA_WIDTH-1:0];
    end

    assign in_ready  = (fill_reg != shrb_pkg::QFILL_W'(shrb_pkg::QDEPTH));
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = q_mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Hold queued command payloads
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= entry_in;
        end
    end

endmodule

// ----- rtl/core/shrb_back.sv -----
// Back end: executes queued commands against the payload store and id state.
// Depends on shrb_pkg (cmd_t, state enum, wrap_add).
`timescale 1ns / 1ps

module shrb_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  shrb_pkg::cmd_t                   cmd,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [shrb_pkg::STATUS_W-1:0]    status,
    output logic [shrb_pkg::ID_W-1:0]        assigned_id,
    output logic                             overwrote,
    output logic [shrb_pkg::FRAME_W-1:0]     frame_out,
    output logic [shrb_pkg::ID_W-1:0]        oldest_id,
    output logic [shrb_pkg::ID_W-1:0]        next_id_out,
    output logic [shrb_pkg::CNT_W-1:0]       entry_count
);

    // Payload store
    shrb_pkg::data_t             mem [shrb_pkg::DEPTH];
    shrb_pkg::data_t             rd_data_reg;
    logic                        mem_wr_en;
    shrb_pkg::idx_t              mem_wr_addr;
    logic                        mem_rd_en;
    shrb_pkg::idx_t              mem_rd_addr;

    // Control and id state
    shrb_pkg::back_state_t       state_reg, state_next;
    shrb_pkg::idx_t              head_reg, head_next;
    shrb_pkg::cnt_t              count_reg, count_next;
    shrb_pkg::id_t               next_id_reg, next_id_next;
    shrb_pkg::id_t               oldest_reg, oldest_next;

    // Latched command and precomputed compares
    shrb_pkg::cmd_t              cmd_reg, cmd_next;
    logic                        lt_old_reg, eq_old_reg, ge_next_reg, off_lt_reg, wrap_reg;
    shrb_pkg::cnt_t              off_lo_reg;
    logic [shrb_pkg::ID_W:0]     diff_full;
    logic [shrb_pkg::ID_W:0]     span_full;
    shrb_pkg::id_t               off;

    // Result register
    logic                        out_valid_reg, out_valid_next;
    shrb_pkg::status_t           status_reg, status_next;
    shrb_pkg::id_t               assigned_reg, assigned_next;
    logic                        over_reg, over_next;
    shrb_pkg::frame_t            frame_reg, frame_next;

    logic                        full;
    shrb_pkg::cnt_t              k;

    // Wide compares of the query id against the held id window
    always_comb
    begin
        diff_full = {1'b0, cmd_reg.qid} - {1'b0, oldest_reg};
        off       = diff_full[shrb_pkg::ID_W-1:0];
        span_full = {1'b0, oldest_reg} + (shrb_pkg::ID_W + 1)'(count_reg - 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == shrb_pkg::BK_CALC)
        begin
            lt_old_reg  <= diff_full[shrb_pkg::ID_W];
            eq_old_reg  <= (cmd_reg.qid == oldest_reg);
            ge_next_reg <= (cmd_reg.qid >= next_id_reg);
            off_lt_reg  <= (off < shrb_pkg::ID_W'(count_reg));
            off_lo_reg  <= off[shrb_pkg::CNT_W-1:0];
            wrap_reg    <= span_full[shrb_pkg::ID_W];
        end
    end

    // Next state, state updates and result
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        next_id_next   = next_id_reg;
        oldest_next    = oldest_reg;
        cmd_next       = cmd_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        assigned_next  = assigned_reg;
        over_next      = over_reg;
        frame_next     = frame_reg;
        cmd_ready      = 1'b0;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = head_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = head_reg;
        full           = (count_reg == shrb_pkg::CNT_W'(shrb_pkg::DEPTH));
        k              = '0;

        // Drop the result once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            shrb_pkg::BK_IDLE:
            begin
                if (cmd_valid && (!out_valid_reg || out_ready))
                begin
                    cmd_ready  = 1'b1;
                    cmd_next   = cmd;
                    state_next = shrb_pkg::BK_CALC;
                end
            end
            shrb_pkg::BK_CALC:
            begin
                state_next = shrb_pkg::BK_EXEC;
            end
            shrb_pkg::BK_EXEC:
            begin
                status_next   = shrb_pkg::STAT_OK;
                assigned_next = '0;
                over_next     = 1'b0;
                frame_next    = '0;
                state_next    = shrb_pkg::BK_IDLE;
                case (cmd_reg.op)
                    shrb_pkg::OP_PUSH:
                    begin
                        // Overwrite the oldest slot when full
                        mem_wr_en     = 1'b1;
                        mem_wr_addr   = full ? head_reg
                                             : shrb_pkg::wrap_add(head_reg, count_reg);
                        head_next     = full ? shrb_pkg::wrap_add(head_reg, shrb_pkg::CNT_W'(1))
                                             : head_reg;
                        count_next    = full ? count_reg : count_reg + 1'b1;
                        oldest_next   = full ? oldest_reg + 1'b1 : oldest_reg;
                        next_id_next  = next_id_reg + 1'b1;
                        assigned_next = next_id_reg;
                        over_next     = full;
                        out_valid_next = 1'b1;
                    end
                    shrb_pkg::OP_GET:
                    begin
                        if ((count_reg == '0) || ge_next_reg)
                        begin
                            status_next    = shrb_pkg::STAT_NOT_FOUND;
                            out_valid_next = 1'b1;
                        end
                        else if (lt_old_reg)
                        begin
                            status_next    = shrb_pkg::STAT_EVICTED;
                            out_valid_next = 1'b1;
                        end
                        else if (!off_lt_reg)
                        begin
                            status_next    = shrb_pkg::STAT_NOT_FOUND;
                            out_valid_next = 1'b1;
                        end
                        else
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = shrb_pkg::wrap_add(head_reg, off_lo_reg);
                            state_next  = shrb_pkg::BK_READ;
                        end
                    end
                    shrb_pkg::OP_DISCARD:
                    begin
                        // Count leading entries below the given id
                        if ((count_reg == '0) || lt_old_reg || eq_old_reg)
                        begin
                            k = '0;
                        end
                        else if (wrap_reg || !off_lt_reg)
                        begin
                            k = count_reg;
                        end
                        else
                        begin
                            k = off_lo_reg;
                        end
                        head_next      = shrb_pkg::wrap_add(head_reg, k);
                        count_next     = count_reg - k;
                        oldest_next    = oldest_reg + shrb_pkg::ID_W'(k);
                        out_valid_next = 1'b1;
                    end
                    default:
                    begin
                        head_next      = '0;
                        count_next     = '0;
                        oldest_next    = next_id_reg;
                        out_valid_next = 1'b1;
                    end
                endcase
            end
            shrb_pkg::BK_READ:
            begin
                frame_next     = shrb_pkg::frame_t'(rd_data_reg);
                status_next    = shrb_pkg::STAT_OK;
                out_valid_next = 1'b1;
                state_next     = shrb_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = shrb_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= shrb_pkg::BK_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            next_id_reg   <= '0;
            oldest_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            next_id_reg   <= next_id_next;
            oldest_reg    <= oldest_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold command and result payloads
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        status_reg   <= status_next;
        assigned_reg <= assigned_next;
        over_reg     <= over_next;
        frame_reg    <= frame_next;
    end

    // Store write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_wr_addr] <= cmd_reg.data;
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= mem[mem_rd_addr];
        end
    end

    // Id state stays put while a result waits, so show it directly
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign assigned_id = assigned_reg;
    assign overwrote   = over_reg;
    assign frame_out   = frame_reg;
    assign oldest_id   = oldest_reg;
    assign next_id_out = next_id_reg;
    assign entry_count = count_reg;

endmodule

// ----- rtl/core/sequenced_history_ring_buffer.sv -----
// Top level of the sequenced history ring buffer: front queue plus back executor.
// Depends on shrb_pkg, shrb_front and shrb_back.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  input    | in_valid / in_ready  | op, query_id, frame_data
//  output   | out_valid / out_ready| status, assigned_id, overwrote, frame_out,
//           |                      | oldest_id, next_id_out, entry_count
//
// Push, discard and purge pass through the take, compare and execute states in the back end;
// a get that hits adds a read state for the registered store read.
// The back end starts the next command only once its result register is free.
// The front holds up to two commands, so input beats are taken while the back works.
// Reset clears the pointers, count and id counter at once; the store needs no clearing.
`timescale 1ns / 1ps

module sequenced_history_ring_buffer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [shrb_pkg::OP_W-1:0]        op,
    input  logic [shrb_pkg::ID_W-1:0]        query_id,
    input  logic [shrb_pkg::FRAME_W-1:0]     frame_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [shrb_pkg::STATUS_W-1:0]    status,
    output logic [shrb_pkg::ID_W-1:0]        assigned_id,
    output logic                             overwrote,
    output logic [shrb_pkg::FRAME_W-1:0]     frame_out,
    output logic [shrb_pkg::ID_W-1:0]        oldest_id,
    output logic [shrb_pkg::ID_W-1:0]        next_id_out,
    output logic [shrb_pkg::CNT_W-1:0]       entry_count
);

    logic            cmd_valid;
    logic            cmd_ready;
    shrb_pkg::cmd_t  cmd;

    shrb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .query_id   (query_id),
        .frame_data (frame_data),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd)
    );

    shrb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .assigned_id (assigned_id),
        .overwrote   (overwrote),
        .frame_out   (frame_out),
        .oldest_id   (oldest_id),
        .next_id_out (next_id_out),
        .entry_count (entry_count)
    );

endmodule
